[sv/homogeneous_point_transform_defines.svh]
// Assertion macros for the homogeneous point transform
`ifndef HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS
`define HPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpt: same-cycle check failed");
`define HPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpt: next-cycle check failed");
`else
`define HPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/hpt_pkg.sv]
package hpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int MW        = 64;
    localparam int AW        = MW + 2;
    localparam int QW        = CW + 1;
    localparam int NW        = MW + FRAC_BITS + 1;
    localparam int SQW       = MW / 2;
    localparam int PW        = $clog2(MW);
    localparam int NREG      = 8;
    localparam int RIW       = $clog2(NREG);
    localparam int PAW       = RIW + 3;
    localparam int NORM_MSB  = CW - 2;

    localparam logic [1:0] ACT_POINT  = 2'd0;
    localparam logic [1:0] ACT_VECTOR = 2'd1;
    localparam logic [1:0] ACT_NORMAL = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [RIW-1:0] REG_ROW0_FIRST  = 3'd0;
    localparam logic [RIW-1:0] REG_ROW0_SECOND = 3'd1;
    localparam logic [RIW-1:0] REG_ROW1_FIRST  = 3'd2;
    localparam logic [RIW-1:0] REG_ROW1_SECOND = 3'd3;
    localparam logic [RIW-1:0] REG_ROW2_FIRST  = 3'd4;
    localparam logic [RIW-1:0] REG_ROW2_SECOND = 3'd5;
    localparam logic [RIW-1:0] REG_ROW3_FIRST  = 3'd6;
    localparam logic [RIW-1:0] REG_ROW3_SECOND = 3'd7;

    localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] NEG_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [MW-1:0] ONE_LO  = MW'(1) << FRAC_BITS;
    localparam logic [MW-1:0] ONE_HI  = ONE_LO << CW;

    typedef struct packed {
        logic                   sat;
        logic [CW-1:0]          val;
    } t_clamp;

    typedef struct packed {
        logic [1:0]             act;
        logic                   zero;
        logic [2:0]             neg;
        logic [2:0][CW-1:0]     vval;
        logic                   vsat;
        logic [2:0][MW-1:0]     amag;
        logic [MW-1:0]          wmag;
        logic [2:0][CW-1:0]     ms;
    } t_side_pre;

    typedef struct packed {
        logic [1:0]             act;
        logic                   zero;
        logic [2:0]             neg;
        logic [2:0][CW-1:0]     vval;
        logic                   vsat;
    } t_side_post;

    function automatic logic [MW-1:0] cfg_reset(input logic [RIW-1:0] idx);
        logic [MW-1:0] v;
        case (idx)
            REG_ROW0_FIRST:  v = ONE_LO;
            REG_ROW1_FIRST:  v = ONE_HI;
            REG_ROW2_SECOND: v = ONE_LO;
            REG_ROW3_SECOND: v = ONE_HI;
            default:         v = '0;
        endcase
        return v;
    endfunction

    function automatic t_clamp hpt_clamp(input logic [MW-1:0] mag, input logic neg,
                                         input logic ovf);
        t_clamp c;
        c.sat = 1'b0;
        c.val = '0;
        if (!neg) begin
            if (ovf || mag > MW'(POS_MAX)) begin
                c.sat = 1'b1;
                c.val = POS_MAX;
            end else begin
                c.val = mag[CW-1:0];
            end
        end else begin
            if (ovf || mag > MW'(NEG_MIN)) begin
                c.sat = 1'b1;
                c.val = NEG_MIN;
            end else begin
                c.val = -mag[CW-1:0];
            end
        end
        return c;
    endfunction

endpackage

[sv/hpt_div.sv]
module hpt_div import hpt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0][MW-1:0]     i_num,
    input  logic [MW-1:0]          i_den,
    input  t_side_post             i_side,
    output logic                   o_valid,
    output logic [2:0][QW-1:0]     o_q,
    output logic [2:0]             o_ovf,
    output t_side_post             o_side
);

    logic [2:0][NW-1:0]   r_n;
    logic [MW-1:0]        r_n_den;
    logic                 r_n_v;
    t_side_post           r_n_side;

    logic [2:0][MW-1:0]   r_h_rem;
    logic [2:0][QW-1:0]   r_h_lo;
    logic [2:0]           r_h_ovf;
    logic [MW-1:0]        r_h_den;
    logic                 r_h_v;
    t_side_post           r_h_side;

    logic [2:0][MW-1:0]   r_rem  [QW];
    logic [2:0][QW-1:0]   r_lo   [QW];
    logic [2:0][QW-1:0]   r_q    [QW];
    logic [2:0]           r_ovf  [QW];
    logic [MW-1:0]        r_den  [QW];
    logic                 r_v    [QW];
    t_side_post           r_side [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (i_en) begin
            r_n_v <= i_valid;
            r_h_v <= r_n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_n[l]     <= (NW'(i_num[l]) << FRAC_BITS) + NW'(i_den >> 1);
                r_h_rem[l] <= MW'(r_n[l][NW-1:QW]);
                r_h_lo[l]  <= r_n[l][QW-1:0];
                r_h_ovf[l] <= MW'(r_n[l][NW-1:QW]) >= r_n_den;
            end
            r_n_den  <= i_den;
            r_n_side <= i_side;
            r_h_den  <= r_n_den;
            r_h_side <= r_n_side;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [2:0][MW-1:0] p_rem;
        logic [2:0][QW-1:0] p_lo;
        logic [2:0][QW-1:0] p_q;
        logic [2:0]         p_ovf;
        logic [MW-1:0]      p_den;
        logic               p_v;
        t_side_post         p_side;
        logic [2:0][MW-1:0] n_rem;
        logic [2:0][QW-1:0] n_q;

        if (k == 0) begin : g_first
            assign p_rem  = r_h_rem;
            assign p_lo   = r_h_lo;
            assign p_q    = '0;
            assign p_ovf  = r_h_ovf;
            assign p_den  = r_h_den;
            assign p_v    = r_h_v;
            assign p_side = r_h_side;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_lo   = r_lo[k-1];
            assign p_q    = r_q[k-1];
            assign p_ovf  = r_ovf[k-1];
            assign p_den  = r_den[k-1];
            assign p_v    = r_v[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            logic [MW:0] t;
            logic        ge;
            for (int l = 0; l < 3; l++) begin
                t        = {p_rem[l], p_lo[l][QW-1-k]};
                ge       = t >= {1'b0, p_den};
                n_rem[l] = ge ? MW'(t - {1'b0, p_den}) : t[MW-1:0];
                n_q[l]   = {p_q[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_lo[k]   <= p_lo;
                r_q[k]    <= n_q;
                r_ovf[k]  <= p_ovf;
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_ovf   = r_ovf[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

[sv/hpt_isqrt.sv]
module hpt_isqrt import hpt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [MW-1:0]   i_s,
    input  t_side_pre       i_side,
    output logic            o_valid,
    output logic [CW-1:0]   o_root,
    output t_side_pre       o_side
);

    logic [MW-1:0] r_rem  [SQW];
    logic [MW-1:0] r_root [SQW];
    logic          r_v    [SQW];
    t_side_pre     r_side [SQW];

    for (genvar k = 0; k < SQW; k++) begin : g_step
        localparam logic [MW-1:0] BIT = MW'(1) << (MW - 2 - 2 * k);
        logic [MW-1:0] p_rem;
        logic [MW-1:0] p_root;
        logic          p_v;
        t_side_pre     p_side;
        logic [MW-1:0] n_rem;
        logic [MW-1:0] n_root;

        if (k == 0) begin : g_first
            assign p_rem  = i_s;
            assign p_root = '0;
            assign p_v    = i_valid;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_v    = r_v[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            if (p_rem >= p_root + BIT) begin
                n_rem  = p_rem - (p_root + BIT);
                n_root = (p_root >> 1) + BIT;
            end else begin
                n_rem  = p_rem;
                n_root = p_root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[SQW-1];
    assign o_root  = r_root[SQW-1][CW-1:0];
    assign o_side  = r_side[SQW-1];

endmodule

[sv/homogeneous_point_transform.sv]
// Pipeline: 8 front stages, a 32-stage square root and a 35-stage divider (its
// last stages yield one quotient bit each), then an output register.
// Throughput: one transaction per cycle; the pipeline stalls as a whole while a
// result waits on the output.
// Reset: synchronous, active low; clears valid bits and loads the identity matrix.
`include "homogeneous_point_transform_defines.svh"

module homogeneous_point_transform import hpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_action,
    input  logic signed [CW-1:0] i_in_x,
    input  logic signed [CW-1:0] i_in_y,
    input  logic signed [CW-1:0] i_in_z,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [CW-1:0] o_out_x,
    output logic signed [CW-1:0] o_out_y,
    output logic signed [CW-1:0] o_out_z,
    output logic [1:0]           o_status,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PAW-1:0]       paddr,
    input  logic [MW-1:0]        pwdata,
    output logic [MW-1:0]        prdata,
    output logic                 pready
);

    logic [MW-1:0] r_cfg [NREG];
    logic          en;

    logic signed [CW-1:0]        coef [4][4];
    logic signed [CW-1:0]        vin  [3];

    logic                        r_a_v;
    logic [1:0]                  r_a_act;
    logic signed [MW-1:0]        r_a_prod [4][3];
    logic signed [CW-1:0]        r_a_tr   [4];

    logic                        r_b_v;
    logic [1:0]                  r_b_act;
    logic signed [AW-1:0]        r_b_acc [4];

    logic                        r_c_v;
    logic [1:0]                  r_c_act;
    logic [3:0][MW-1:0]          r_c_mag;
    logic [3:0]                  r_c_neg;

    logic                        r_d_v;
    t_side_pre                   r_d_side;
    logic [2:0]                  r_d_hb;
    logic [7:0]                  r_d_byte;
    t_side_pre                   n_d_side;
    logic [2:0]                  n_d_hb;
    logic [7:0]                  n_d_byte;

    logic                        r_e_v;
    t_side_pre                   r_e_side;
    logic                        r_e_right;
    logic [PW-1:0]               r_e_amt;
    logic [PW-1:0]               n_e_p;

    logic                        r_f_v;
    t_side_pre                   r_f_side;
    t_side_pre                   n_f_side;

    logic                        r_g_v;
    t_side_pre                   r_g_side;
    logic [2:0][2*(CW-1)-1:0]    r_g_sq;

    logic                        r_h_v;
    t_side_pre                   r_h_side;
    logic [MW-1:0]               r_h_s;

    logic                        sq_v;
    logic [CW-1:0]               sq_root;
    t_side_pre                   sq_side;

    logic [2:0][MW-1:0]          dv_num;
    logic [MW-1:0]               dv_den;
    t_side_post                  dv_side_in;

    logic                        dq_v;
    logic [2:0][QW-1:0]          dq_q;
    logic [2:0]                  dq_ovf;
    t_side_post                  dq_side;

    logic                        r_out_valid;
    logic [2:0][CW-1:0]          r_out_val;
    logic [1:0]                  r_out_status;
    logic [2:0][CW-1:0]          n_out_val;
    logic [1:0]                  n_out_status;

    assign pready = 1'b1;
    assign prdata = r_cfg[paddr[PAW-1:3]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NREG; i++) begin
                r_cfg[i] <= cfg_reset(RIW'(i));
            end
        end else if (psel && penable && pwrite) begin
            r_cfg[paddr[PAW-1:3]] <= pwdata;
        end
    end

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                coef[r][j] = j[0] ? r_cfg[2*r + j/2][MW-1:CW] : r_cfg[2*r + j/2][CW-1:0];
            end
        end
        vin[0] = i_in_x;
        vin[1] = i_in_y;
        vin[2] = i_in_z;
    end

    // multiply
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_act <= i_action;
            for (int r = 0; r < 4; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_a_prod[r][j] <= coef[r][j] * vin[j];
                end
                r_a_tr[r] <= coef[r][3];
            end
        end
    end

    // accumulate
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_act <= r_a_act;
            for (int r = 0; r < 4; r++) begin
                r_b_acc[r] <= AW'(r_a_prod[r][0]) + AW'(r_a_prod[r][1]) + AW'(r_a_prod[r][2])
                            + ((r == 3 || r_a_act == ACT_POINT)
                               ? (AW'(r_a_tr[r]) <<< FRAC_BITS) : AW'(0));
            end
        end
    end

    // magnitude and sign
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_act <= r_b_act;
            for (int r = 0; r < 4; r++) begin
                r_c_neg[r] <= r_b_acc[r][AW-1];
                r_c_mag[r] <= r_b_acc[r][AW-1] ? MW'(-r_b_acc[r]) : MW'(r_b_acc[r]);
            end
        end
    end

    // vector rounding, zero checks, leading byte
    always_comb begin
        logic [MW-1:0] orv;
        logic [MW:0]   vs;
        t_clamp        c;
        n_d_side      = '0;
        n_d_side.act  = r_c_act;
        n_d_side.amag = r_c_mag[2:0];
        n_d_side.wmag = r_c_mag[3];
        n_d_side.vsat = 1'b0;
        orv = r_c_mag[0] | r_c_mag[1] | r_c_mag[2];
        for (int l = 0; l < 3; l++) begin
            vs = {1'b0, r_c_mag[l]} + ((MW+1)'(1) << (FRAC_BITS - 1));
            c  = hpt_clamp(MW'(vs >> FRAC_BITS), r_c_neg[l], 1'b0);
            n_d_side.vval[l] = c.val;
            n_d_side.vsat    = n_d_side.vsat | c.sat;
            n_d_side.neg[l]  = (r_c_act == ACT_POINT) ? (r_c_neg[l] ^ r_c_neg[3]) : r_c_neg[l];
        end
        if (r_c_act == ACT_POINT) begin
            n_d_side.zero = (r_c_mag[3] == '0);
        end else if (r_c_act == ACT_NORMAL) begin
            n_d_side.zero = (orv == '0);
        end else begin
            n_d_side.zero = 1'b0;
        end
        n_d_hb   = '0;
        n_d_byte = '0;
        for (int i = 0; i < MW/8; i++) begin
            if (orv[8*i +: 8] != '0) begin
                n_d_hb   = 3'(i);
                n_d_byte = orv[8*i +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side <= n_d_side;
            r_d_hb   <= n_d_hb;
            r_d_byte <= n_d_byte;
        end
    end

    // leading bit and shift amount
    always_comb begin
        logic [2:0] bp;
        bp = '0;
        for (int i = 0; i < 8; i++) begin
            if (r_d_byte[i]) begin
                bp = 3'(i);
            end
        end
        n_e_p = {r_d_hb, bp};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_side  <= r_d_side;
            r_e_right <= n_e_p >= PW'(NORM_MSB);
            r_e_amt   <= (n_e_p >= PW'(NORM_MSB)) ? n_e_p - PW'(NORM_MSB)
                                                  : PW'(NORM_MSB) - n_e_p;
        end
    end

    // normalize
    always_comb begin
        n_f_side = r_e_side;
        for (int l = 0; l < 3; l++) begin
            n_f_side.ms[l] = r_e_right ? CW'(r_e_side.amag[l] >> r_e_amt)
                                       : CW'(r_e_side.amag[l] << r_e_amt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_side <= n_f_side;
        end
    end

    // square
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_side <= r_f_side;
            for (int l = 0; l < 3; l++) begin
                r_g_sq[l] <= r_f_side.ms[l][CW-2:0] * r_f_side.ms[l][CW-2:0];
            end
        end
    end

    // sum of squares
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_side <= r_g_side;
            r_h_s    <= MW'(r_g_sq[0]) + MW'(r_g_sq[1]) + MW'(r_g_sq[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
        end
    end

    hpt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_v),
        .i_s     (r_h_s),
        .i_side  (r_h_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            dv_num[l] = (sq_side.act == ACT_POINT) ? sq_side.amag[l] : MW'(sq_side.ms[l]);
        end
        dv_den          = (sq_side.act == ACT_POINT) ? sq_side.wmag : MW'(sq_root);
        dv_side_in.act  = sq_side.act;
        dv_side_in.zero = sq_side.zero;
        dv_side_in.neg  = sq_side.neg;
        dv_side_in.vval = sq_side.vval;
        dv_side_in.vsat = sq_side.vsat;
    end

    hpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .i_side  (dv_side_in),
        .o_valid (dq_v),
        .o_q     (dq_q),
        .o_ovf   (dq_ovf),
        .o_side  (dq_side)
    );

    // clamp and status
    always_comb begin
        t_clamp c;
        logic   sat;
        sat = 1'b0;
        for (int l = 0; l < 3; l++) begin
            if (dq_side.act == ACT_POINT || dq_side.act == ACT_NORMAL) begin
                c = hpt_clamp(MW'(dq_q[l]), dq_side.neg[l], dq_ovf[l]);
            end else begin
                c.val = dq_side.vval[l];
                c.sat = dq_side.vsat;
            end
            n_out_val[l] = dq_side.zero ? '0 : c.val;
            sat          = sat | c.sat;
        end
        if (dq_side.zero) begin
            n_out_status = ST_ZERO;
        end else if (sat) begin
            n_out_status = ST_SAT;
        end else begin
            n_out_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val    <= n_out_val;
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_val[0];
    assign o_out_y     = r_out_val[1];
    assign o_out_z     = r_out_val[2];
    assign o_status    = r_out_status;

    `HPT_ASSERT_IMP(a_zero_clears, i_clk, i_rst_n, o_out_valid && o_status == ST_ZERO, o_out_x == '0 && o_out_y == '0 && o_out_z == '0)
    `HPT_ASSERT_IMP(a_root_range, i_clk, i_rst_n, sq_v && sq_side.act == ACT_NORMAL && !sq_side.zero, sq_root[CW-1:CW-2] != 2'b00)
    `HPT_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_h_v && !en, r_h_v && $stable(r_h_s))

endmodule

[verif/testbench.sv]
module testbench;
    import hpt_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES = 100;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  status;
    } t_coord_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_action = ACT_POINT;
    logic signed [31:0] i_in_x = '0;
    logic signed [31:0] i_in_y = '0;
    logic signed [31:0] i_in_z = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic [1:0]        o_status;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PAW-1:0]    paddr = '0;
    logic [MW-1:0]     pwdata = '0;
    logic [MW-1:0]     prdata;
    logic              pready;

    logic signed [31:0] matrix [16];
    t_coord_result      pending_coords [$];
    int                 mismatches = 0;
    int                 stall_cycles = 0;
    bit                 send_gaps = 1'b1;
    bit                 sink_gaps = 1'b1;

    homogeneous_point_transform DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void row_product(input int r, input bit with_t,
                                        input logic signed [31:0] x, y, z,
                                        output logic [63:0] mag, output bit neg);
        logic signed [67:0] s;
        logic signed [67:0] t;
        s = matrix[r*4] * x + matrix[r*4+1] * y + matrix[r*4+2] * z;
        if (with_t) begin
            t = matrix[r*4+3];
            s = s + (t <<< FRAC_BITS);
        end
        neg = s < 0;
        mag = neg ? 64'(-s) : 64'(s);
    endfunction

    function automatic logic [31:0] saturate(input logic [63:0] q, input bit neg,
                                             inout bit sat);
        if (!neg) begin
            if (q > 64'h7FFF_FFFF) begin
                sat = 1'b1;
                return POS_MAX;
            end
            return q[31:0];
        end
        if (q > 64'h8000_0000) begin
            sat = 1'b1;
            return NEG_MIN;
        end
        return -q[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_coord_result transform_coord(input logic [1:0] act,
                                                      input logic signed [31:0] x, y, z);
        t_coord_result res;
        logic [63:0]   mag [3];
        bit            neg [3];
        logic [63:0]   wmag;
        bit            wneg;
        logic [127:0]  num;
        logic [127:0]  q;
        logic [63:0]   m [3];
        logic [63:0]   mx;
        logic [63:0]   len;
        logic [31:0]   o [3];
        bit            sat;
        bit            zero;
        sat = 1'b0;
        zero = 1'b0;
        for (int r = 0; r < 3; r++) begin
            row_product(r, act == ACT_POINT, x, y, z, mag[r], neg[r]);
            o[r] = '0;
        end
        if (act == ACT_POINT) begin
            row_product(3, 1'b1, x, y, z, wmag, wneg);
            if (wmag == 0) begin
                zero = 1'b1;
            end else begin
                for (int r = 0; r < 3; r++) begin
                    num = ({64'd0, mag[r]} << FRAC_BITS) + (wmag >> 1);
                    q = num / wmag;
                    if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
                    o[r] = saturate(q[63:0], neg[r] != wneg, sat);
                end
            end
        end else if (act == ACT_NORMAL) begin
            for (int r = 0; r < 3; r++) m[r] = mag[r];
            mx = m[0];
            if (m[1] > mx) mx = m[1];
            if (m[2] > mx) mx = m[2];
            if (mx == 0) begin
                zero = 1'b1;
            end else begin
                while (mx >= 64'h8000_0000) begin
                    mx = mx >> 1;
                    for (int r = 0; r < 3; r++) m[r] = m[r] >> 1;
                end
                while (mx < 64'h4000_0000) begin
                    mx = mx << 1;
                    for (int r = 0; r < 3; r++) m[r] = m[r] << 1;
                end
                len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
                for (int r = 0; r < 3; r++)
                    o[r] = saturate(((m[r] << FRAC_BITS) + (len >> 1)) / len, neg[r], sat);
            end
        end else begin
            for (int r = 0; r < 3; r++)
                o[r] = saturate((mag[r] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS,
                                neg[r], sat);
        end
        res.x = o[0];
        res.y = o[1];
        res.z = o[2];
        res.status = zero ? ST_ZERO : (sat ? ST_SAT : ST_OK);
        return res;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return POS_MAX;
            1: return NEG_MIN;
            2: return $urandom;
            3: return 32'($signed($urandom_range(2 * 65536 * 16)) - 65536 * 16);
            4: return $urandom_range(1) ? Q_ONE : -Q_ONE;
            default: return 32'($signed($urandom_range(65536 * 512)) - 65536 * 256);
        endcase
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 33) return ACT_POINT;
        if (r < 63) return ACT_VECTOR;
        if (r < 95) return ACT_NORMAL;
        return ACT_UNUSED;
    endfunction

    task automatic write_matrix_reg(input logic [RIW-1:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        matrix[idx*2] = val[31:0];
        matrix[idx*2+1] = val[63:32];
    endtask

    task automatic wait_drained();
        while (pending_coords.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_matrix(input logic [31:0] c [16]);
        wait_drained();
        for (int k = 0; k < NREG; k++)
            write_matrix_reg(RIW'(k), {c[2*k+1], c[2*k]});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_coord(input logic [1:0] act, input logic [31:0] x, y, z);
        while (send_gaps && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_in_x <= x;
        i_in_y <= y;
        i_in_z <= z;
        do @(posedge i_clk); while (o_in_stall);
        pending_coords.push_back(transform_coord(act, x, y, z));
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
    endtask

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++)
            send_coord(pick_action(), pick_value(), pick_value(), pick_value());
        end_burst();
    endtask

    task automatic test_directed();
        logic [31:0] c [16];
        send_coord(ACT_POINT, 0, 0, 0);
        send_coord(ACT_POINT, POS_MAX, POS_MAX, POS_MAX);
        send_coord(ACT_POINT, NEG_MIN, NEG_MIN, NEG_MIN);
        send_coord(ACT_VECTOR, POS_MAX, NEG_MIN, Q_ONE);
        send_coord(ACT_NORMAL, POS_MAX, NEG_MIN, 0);
        send_coord(ACT_NORMAL, 0, 0, 0);
        send_coord(ACT_NORMAL, 1, 0, 0);
        send_coord(ACT_NORMAL, Q_ONE, Q_ONE, Q_ONE);
        send_coord(ACT_UNUSED, -Q_ONE, 32'h1234_5678, 32'hFFFF_FFFF);
        end_burst();
        for (int k = 0; k < 16; k++) c[k] = (k % 5 == 0) ? 2 * Q_ONE : 0;
        load_matrix(c);
        send_coord(ACT_VECTOR, POS_MAX, NEG_MIN, 32'h4000_0000);
        send_coord(ACT_POINT, POS_MAX, NEG_MIN, 5);
        send_coord(ACT_NORMAL, NEG_MIN, NEG_MIN, NEG_MIN);
        end_burst();
        c[15] = 0;
        load_matrix(c);
        send_coord(ACT_POINT, Q_ONE, 2, 3);
        send_coord(ACT_VECTOR, Q_ONE, 2, 3);
        end_burst();
        c[12] = Q_ONE;
        c[15] = -Q_ONE;
        load_matrix(c);
        send_coord(ACT_POINT, Q_ONE, 7, 9);
        send_coord(ACT_POINT, 3 * Q_ONE, 7, 9);
        send_coord(ACT_POINT, 32'h0001_0001, 7, 9);
        end_burst();
    endtask

    task automatic test_extreme_matrices();
        logic [31:0] c [16];
        for (int k = 0; k < 16; k++) c[k] = NEG_MIN;
        load_matrix(c);
        send_random(100);
        for (int k = 0; k < 16; k++) c[k] = POS_MAX;
        load_matrix(c);
        send_random(100);
    endtask

    task automatic test_random_matrices();
        logic [31:0] c [16];
        for (int p = 0; p < 5; p++) begin
            for (int k = 0; k < 16; k++) c[k] = pick_value();
            load_matrix(c);
            send_random(145);
        end
    endtask

    task automatic test_no_gaps();
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        send_random(150);
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        send_random(60);
        while (pending_coords.size() != 0) @(posedge i_clk);
        send_random(60);
    endtask

    task automatic test_identity_random();
        logic [31:0] c [16];
        for (int k = 0; k < 16; k++) c[k] = (k % 5 == 0) ? Q_ONE : 0;
        load_matrix(c);
        send_random(150);
    endtask

    always @(posedge i_clk) begin
        t_coord_result want;
        i_out_stall <= i_rst_n && sink_gaps && ($urandom_range(99) < 25);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_coords.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h z=%h status=%0d",
                             o_out_x, o_out_y, o_out_z, o_status);
            end else begin
                want = pending_coords.pop_front();
                if (o_out_x !== want.x || o_out_y !== want.y || o_out_z !== want.z ||
                    o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %h st %0d, got %h %h %h st %0d",
                                 want.x, want.y, want.z, want.status,
                                 o_out_x, o_out_y, o_out_z, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 16; k++) matrix[k] = (k % 5 == 0) ? Q_ONE : 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_identity_random();
        test_extreme_matrices();
        test_random_matrices();
        test_no_gaps();
        test_pause_until_drained();
        wait_drained();
        if (mismatches == 0 && pending_coords.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
